// ===== rtl/wstf_pkg.sv =====
// wstf_pkg: shared types, constants and fixed point helpers for the wave shaped
// transfer function. Used by wave_shaped_transfer_function.
// No dependencies.
package wstf_pkg;

  localparam int FRAC_BITS = 16;
  localparam logic [16:0] ONE  = 17'h10000;
  localparam logic [16:0] HALF = 17'h08000;

  typedef enum logic [1:0] {
    WM_NONE = 2'd0,
    WM_TRI  = 2'd1,
    WM_SINE = 2'd2,
    WM_RECT = 2'd3
  } wave_mode_e;

  typedef enum logic [2:0] {
    CFG_WAVE_MODE     = 3'd0,
    CFG_CYCLE_COUNT   = 3'd1,
    CFG_TILT          = 3'd2,
    CFG_SHAPE_BIAS    = 3'd3,
    CFG_LOW_CUTOFF    = 3'd4,
    CFG_HIGH_CUTOFF   = 3'd5,
    CFG_SMOOTH_ENABLE = 3'd6
  } cfg_idx_e;

  // clamp a signed Q1.16 value to -1..+1
  function automatic logic signed [17:0] sat_q16(logic signed [17:0] x);
    logic signed [17:0] r;
    r = x;
    if (x > 18'sd65536) begin
      r = 18'sd65536;
    end else if (x < -18'sd65536) begin
      r = -18'sd65536;
    end
    return r;
  endfunction

  // (v*v) >> FRAC_BITS, v in 0..ONE
  function automatic logic [16:0] sq_q16(logic [16:0] v);
    logic [33:0] p;
    p = {17'b0, v} * {17'b0, v};
    return p[32:16];
  endfunction

  // (t*(3*ONE-2*v)) >> FRAC_BITS, stays within 0..ONE for t = sq_q16(v)
  function automatic logic [16:0] smooth_fin(logic [16:0] t, logic [16:0] v);
    logic [17:0] f;
    logic [34:0] p;
    f = 18'h30000 - {v, 1'b0};
    p = {18'b0, t} * {17'b0, f};
    return p[32:16];
  endfunction

endpackage

// ===== rtl/wstf_div.sv =====
// wstf_div: pipelined restoring divider, one quotient bit per register stage,
// with a sideband word that travels alongside. Uses no package.
// Quotient = {hi_i, lo_i} / den_i, valid when hi_i < den_i.
module wstf_div #(
  parameter int DEN_W  = 17,
  parameter int Q_W    = 17,
  parameter int SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [DEN_W-1:0]  hi_i,
  input  logic [Q_W-1:0]    lo_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [Q_W-1:0]    quot_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [Q_W-1:0]    vld_q;
  logic [DEN_W-1:0]  rem_q  [Q_W];
  logic [Q_W-1:0]    wrk_q  [Q_W];
  logic [DEN_W-1:0]  den_q  [Q_W];
  logic [SIDE_W-1:0] side_q [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic              vld_in;
    logic [DEN_W-1:0]  rem_in;
    logic [Q_W-1:0]    wrk_in;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              take;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = hi_i;
      assign wrk_in  = lo_i;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign wrk_in  = wrk_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    // shift in the next dividend bit, subtract when it fits
    assign trial = {rem_in, wrk_in[Q_W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign take  = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        wrk_q[k]  <= {wrk_in[Q_W-2:0], take};
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[Q_W-1];
  assign quot_o  = wrk_q[Q_W-1];
  assign side_o  = side_q[Q_W-1];

endmodule

// ===== rtl/wave_shaped_transfer_function.sv =====
// wave_shaped_transfer_function: top level, wave generator, edge shaping, cutoff
// rescale and smoothstep as one pipeline. Depends on wstf_pkg and wstf_div.
//
//   channel   direction  handshake                  payload
//   in        sink       in_valid_i / in_stall_o    sample_i  [23:0] Q8.16
//   out       source     out_valid_o / out_stall_i  level_o   [16:0] Q1.16
//   cfg       sink       cfg_we_i                   cfg_idx_i, cfg_data_i [17:0]
//
// one item per cycle unless a stall on the output holds the pipeline
// the four dividers (32, 17, 18 and 17 bit quotients, one bit per stage) set
// the depth; eleven more stages hold the multiplies, compares and muxes
// a stall on the output freezes the whole pipeline and is passed to in_stall_o
// reset clears all valid bits and loads the register defaults
module wave_shaped_transfer_function
  import wstf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [23:0] sample_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [16:0] level_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [17:0] cfg_data_i
);

  // configuration registers
  wave_mode_e         wave_mode_q;
  logic [15:0]        cycle_count_q;
  logic signed [17:0] tilt_q;
  logic signed [17:0] shape_bias_q;
  logic [16:0]        low_cutoff_q;
  logic [16:0]        high_cutoff_q;
  logic               smooth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_mode_q   <= WM_NONE;
      cycle_count_q <= 16'd256;
      tilt_q        <= '0;
      shape_bias_q  <= '0;
      low_cutoff_q  <= '0;
      high_cutoff_q <= ONE;
      smooth_q      <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WAVE_MODE:     wave_mode_q   <= wave_mode_e'(cfg_data_i[1:0]);
        CFG_CYCLE_COUNT:   cycle_count_q <= cfg_data_i[15:0];
        CFG_TILT:          tilt_q        <= $signed(cfg_data_i);
        CFG_SHAPE_BIAS:    shape_bias_q  <= $signed(cfg_data_i);
        CFG_LOW_CUTOFF:    low_cutoff_q  <= cfg_data_i[16:0];
        CFG_HIGH_CUTOFF:   high_cutoff_q <= cfg_data_i[16:0];
        CFG_SMOOTH_ENABLE: smooth_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // values derived from configuration; user must keep them static with items in flight, not enforced
  logic signed [17:0] tl, sb, sb_abs;
  logic signed [18:0] tsum;
  logic [16:0]        t_c, s_mag, oms;
  logic               sb_neg, sb_zero;

  assign tl      = sat_q16(tilt_q);
  assign sb      = sat_q16(shape_bias_q);
  assign tsum    = 19'(tl) + 19'sd65536;
  assign t_c     = tsum[17:1];
  assign sb_neg  = sb < 18'sd0;
  assign sb_zero = sb == 18'sd0;
  assign sb_abs  = sb_neg ? -sb : sb;
  assign s_mag   = sb_abs[16:0];
  assign oms     = ONE - s_mag;

  logic en;
  logic out_vld_q;
  logic [16:0] level_q;

  assign in_stall_o  = out_vld_q && out_stall_i;
  assign en          = !(out_vld_q && out_stall_i);
  assign out_valid_o = out_vld_q;
  assign level_o     = level_q;

  // fraction of sample / cycle_count
  logic        d1_vld;
  logic [31:0] d1_q;
  logic [23:0] d1_smp;

  wstf_div #(.DEN_W(16), .Q_W(32), .SIDE_W(24)) u_div_frac (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(in_valid_i), .hi_i(16'h0000), .lo_i({sample_i, 8'h00}),
    .den_i(cycle_count_q), .side_i(sample_i),
    .valid_o(d1_vld), .quot_o(d1_q), .side_o(d1_smp)
  );

  // pick the triangle edge
  logic [16:0] frac, n1, dn1;
  logic        le1, byp1;

  assign frac = (cycle_count_q == 16'h0000) ? 17'h0 : {1'b0, d1_q[15:0]};
  assign le1  = frac <= t_c;
  assign n1   = le1 ? frac : ONE - frac;
  assign dn1  = le1 ? t_c : ONE - t_c;
  assign byp1 = le1 ? (t_c == 17'h0) : (t_c == ONE);

  logic        s1_vld, s1_byp, s1_one;
  logic [16:0] s1_n, s1_d;
  logic [23:0] s1_smp;

  // edge division
  logic        d2_vld, d2_byp, d2_one;
  logic [16:0] d2_q;
  logic [23:0] d2_smp;

  wstf_div #(.DEN_W(17), .Q_W(17), .SIDE_W(26)) u_div_edge (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(s1_vld), .hi_i({1'b0, s1_n[16:1]}), .lo_i({s1_n[0], 16'h0000}),
    .den_i(s1_d), .side_i({s1_byp, s1_one, s1_smp}),
    .valid_o(d2_vld), .quot_o(d2_q), .side_o({d2_byp, d2_one, d2_smp})
  );

  logic [16:0] v2;
  always_comb begin
    if (d2_byp) begin
      v2 = d2_one ? ONE : 17'h0;
    end else begin
      v2 = (d2_q > ONE) ? ONE : d2_q;
    end
  end

  logic        s2_vld, s2_skip;
  logic [16:0] s2_v;
  logic [23:0] s2_smp;

  logic [33:0] p1, p2;
  assign p1 = {17'b0, s_mag} * {17'b0, s2_v};
  assign p2 = {17'b0, oms} * {17'b0, s2_v};

  logic        s3_vld, s3_skip;
  logic [32:0] s3_p1, s3_p2;
  logic [16:0] s3_v;
  logic [23:0] s3_smp;

  // shape denominator and numerator
  logic [32:0] inv3;
  logic [17:0] dpos3;
  logic [16:0] den3;
  logic [32:0] num3;

  assign inv3  = 33'h1_0000_0000 - s3_p1;
  assign dpos3 = {1'b0, ONE} - {1'b0, s_mag} + {1'b0, s3_p1[32:16]};
  assign den3  = sb_neg ? inv3[32:16] : dpos3[16:0];
  assign num3  = sb_neg ? s3_p2 : {s3_v, 16'h0000};

  logic        s4_vld, s4_skip, s4_dz;
  logic [32:0] s4_num;
  logic [16:0] s4_den, s4_v;
  logic [23:0] s4_smp;

  // shape division
  logic        d3_vld, d3_skip, d3_dz;
  logic [17:0] d3_q;
  logic [16:0] d3_v;
  logic [23:0] d3_smp;

  wstf_div #(.DEN_W(17), .Q_W(18), .SIDE_W(43)) u_div_shape (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(s4_vld), .hi_i({2'b00, s4_num[32:18]}), .lo_i(s4_num[17:0]),
    .den_i(s4_den), .side_i({s4_dz, s4_skip, s4_v, s4_smp}),
    .valid_o(d3_vld), .quot_o(d3_q), .side_o({d3_dz, d3_skip, d3_v, d3_smp})
  );

  logic [16:0] vt5;
  always_comb begin
    if (d3_skip) begin
      vt5 = d3_v;
    end else if (d3_dz) begin
      vt5 = 17'h0;
    end else begin
      vt5 = (d3_q > {1'b0, ONE}) ? ONE : d3_q[16:0];
    end
  end

  logic        s5_vld;
  logic [16:0] s5_vt;
  logic [23:0] s5_smp;

  logic        s6_vld;
  logic [16:0] s6_sq, s6_vt;
  logic [23:0] s6_smp;

  // wave select
  logic [23:0] w7;
  always_comb begin
    case (wave_mode_q)
      WM_TRI:  w7 = {7'b0, s6_vt};
      WM_SINE: w7 = {7'b0, smooth_fin(s6_sq, s6_vt)};
      WM_RECT: w7 = (s6_vt < HALF) ? 24'h0 : {7'b0, ONE};
      default: w7 = s6_smp;
    endcase
  end

  logic        s7_vld;
  logic [23:0] s7_w;

  // cutoff compare and rescale setup
  logic        wlt8, wgt8;
  logic [16:0] n8, dn8;

  assign wlt8 = s7_w < {7'b0, low_cutoff_q};
  assign wgt8 = s7_w > {7'b0, high_cutoff_q};
  assign n8   = s7_w[16:0] - low_cutoff_q;
  assign dn8  = high_cutoff_q - low_cutoff_q;

  logic        s8_vld, s8_byp, s8_one;
  logic [16:0] s8_n, s8_d;

  logic        d4_vld, d4_byp, d4_one;
  logic [16:0] d4_q;

  wstf_div #(.DEN_W(17), .Q_W(17), .SIDE_W(2)) u_div_cut (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(s8_vld), .hi_i({1'b0, s8_n[16:1]}), .lo_i({s8_n[0], 16'h0000}),
    .den_i(s8_d), .side_i({s8_byp, s8_one}),
    .valid_o(d4_vld), .quot_o(d4_q), .side_o({d4_byp, d4_one})
  );

  logic [16:0] c9;
  always_comb begin
    if (d4_byp) begin
      c9 = d4_one ? ONE : 17'h0;
    end else begin
      c9 = (d4_q > ONE) ? ONE : d4_q;
    end
  end

  logic        s9_vld;
  logic [16:0] s9_c;

  logic        s10_vld;
  logic [16:0] s10_sq, s10_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld    <= 1'b0;
      s2_vld    <= 1'b0;
      s3_vld    <= 1'b0;
      s4_vld    <= 1'b0;
      s5_vld    <= 1'b0;
      s6_vld    <= 1'b0;
      s7_vld    <= 1'b0;
      s8_vld    <= 1'b0;
      s9_vld    <= 1'b0;
      s10_vld   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld    <= d1_vld;
      s2_vld    <= d2_vld;
      s3_vld    <= s2_vld;
      s4_vld    <= s3_vld;
      s5_vld    <= d3_vld;
      s6_vld    <= s5_vld;
      s7_vld    <= s6_vld;
      s8_vld    <= s7_vld;
      s9_vld    <= d4_vld;
      s10_vld   <= s9_vld;
      out_vld_q <= s10_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_n    <= n1;
      s1_d    <= dn1;
      s1_byp  <= byp1;
      s1_one  <= le1;
      s1_smp  <= d1_smp;

      s2_v    <= v2;
      s2_skip <= d2_byp || sb_zero;
      s2_smp  <= d2_smp;

      s3_p1   <= p1[32:0];
      s3_p2   <= p2[32:0];
      s3_v    <= s2_v;
      s3_skip <= s2_skip;
      s3_smp  <= s2_smp;

      s4_num  <= num3;
      s4_den  <= den3;
      s4_dz   <= den3 == 17'h0;
      s4_v    <= s3_v;
      s4_skip <= s3_skip;
      s4_smp  <= s3_smp;

      s5_vt   <= vt5;
      s5_smp  <= d3_smp;

      s6_sq   <= sq_q16(s5_vt);
      s6_vt   <= s5_vt;
      s6_smp  <= s5_smp;

      s7_w    <= w7;

      // equal cutoffs with the level between them give one
      s8_byp  <= wlt8 || wgt8 || (high_cutoff_q == low_cutoff_q);
      s8_one  <= !wlt8;
      s8_n    <= n8;
      s8_d    <= dn8;

      s9_c    <= c9;

      s10_sq  <= sq_q16(s9_c);
      s10_c   <= s9_c;

      level_q <= smooth_q ? smooth_fin(s10_sq, s10_c) : s10_c;
    end
  end

endmodule
